// ----- design/assert_macros.svh -----
// Assertion macros shared by the timer slot bank RTL.
// Included by every file that carries concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- design/ptsb_pkg.sv -----
// Package for the periodic timer slot bank: field widths, codes, slot entry type.
// No dependencies; imported by the cell, the controller and the top level.
`timescale 1ns / 1ps

package ptsb_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int ACT_W         = 2;
  localparam int TIME_W        = 32;
  localparam int SLOT_W        = 4;
  localparam int STATUS_W      = 3;
  localparam int RESULT_CAP    = 16;
  localparam int CNT_W         = $clog2(RESULT_CAP + 1);

  localparam int IN_FIELDS_W   = ACT_W + 2 * TIME_W + SLOT_W;
  localparam int IN_DATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W  = STATUS_W + SLOT_W;
  localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Action codes of a request.
  localparam logic [ACT_W-1:0] ACT_ADD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DEL  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RUN  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_RSVD = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_DELETED = 3'd2,
    ST_EXPIRED = 3'd3,
    ST_NONE    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // One timer slot as it travels around the ring of cells.
  typedef struct packed {
    logic              active;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] start;
  } slot_t;

endpackage

// ----- design/ptsb_cell.sv -----
// One storage cell of the slot ring: holds a single timer slot entry.
// Depends on ptsb_pkg for the slot entry type.
`timescale 1ns / 1ps

module ptsb_cell
  import ptsb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  slot_t d_i,
  output slot_t q_o
);

  logic              active_q;
  logic [TIME_W-1:0] period_q;
  logic [TIME_W-1:0] start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (en_i) begin
      active_q <= d_i.active;
    end
  end

  // Period and start are meaningful only while active; no reset.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      period_q <= d_i.period;
      start_q  <= d_i.start;
    end
  end

  assign q_o = '{active: active_q, period: period_q, start: start_q};

endmodule

// ----- design/ptsb_ctrl.sv -----
// Controller of the slot ring: request register, head-of-ring update, result stage.
// Depends on ptsb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptsb_ctrl
  import ptsb_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [TIME_W-1:0] now_ms_i,
  input  logic [TIME_W-1:0] period_ms_i,
  input  logic [SLOT_W-1:0] slot_id_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output status_e           status_o,
  output logic [SLOT_W-1:0] slot_o,
  output logic              last_o,
  output logic              shift_o,
  input  slot_t             head_i,
  output slot_t             wr_o
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_POS = IW'(NUM_SLOTS - 1);

  state_e            state_q, state_d;
  logic [IW-1:0]     pos_q, pos_d;
  logic [ACT_W-1:0]  act_q;
  logic [TIME_W-1:0] now_q, ival_q;
  logic [SLOT_W-1:0] id_q;
  logic              claim_q, claim_d;
  logic [SLOT_W-1:0] claim_idx_q, claim_idx_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              pend_valid_q, pend_valid_d;
  logic [SLOT_W-1:0] pend_slot_q, pend_slot_d;
  logic              out_valid_q;
  status_e           out_status_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic              out_last_q;

  logic              accept, out_free, step, expire;
  logic              push;
  status_e           push_status;
  logic [SLOT_W-1:0] push_slot;
  logic              push_last;
  logic [TIME_W-1:0] elapsed;
  logic [IW+SLOT_W-1:0] idx_ext, id_ext;
  logic [SLOT_W-1:0] idx_slot;

  assign accept   = (state_q == ST_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || out_ready_i;
  assign step     = (state_q == ST_SCAN) && out_free;
  assign elapsed  = now_q - head_i.start;
  assign idx_ext  = {{SLOT_W{1'b0}}, pos_q};
  assign id_ext   = {{IW{1'b0}}, id_q};
  assign idx_slot = idx_ext[SLOT_W-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:   if (step && (pos_q == LAST_POS)) state_d = ST_FINISH;
      ST_FINISH: if (out_free || (act_q == ACT_RSVD)) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Update the slot at the head of the ring
  always_comb begin
    wr_o        = head_i;
    claim_d     = claim_q;
    claim_idx_d = claim_idx_q;
    expire      = 1'b0;
    unique case (act_q)
      ACT_ADD: begin
        if (!claim_q && !head_i.active) begin
          wr_o.active = 1'b1;
          wr_o.period = ival_q;
          wr_o.start  = now_q;
          claim_d     = step;
          claim_idx_d = idx_slot;
        end
      end
      ACT_DEL: begin
        if (idx_ext == id_ext) wr_o.active = 1'b0;
      end
      ACT_RUN: begin
        if (head_i.active && (elapsed >= head_i.period)) begin
          wr_o.start = now_q;
          expire     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result generation: an expiry is held back until the next expiry or the finish, so its last flag is known
  always_comb begin
    push         = 1'b0;
    push_status  = ST_NONE;
    push_slot    = '0;
    push_last    = 1'b1;
    cnt_d        = cnt_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    pos_d        = pos_q;
    if (accept) begin
      pos_d        = '0;
      cnt_d        = '0;
      pend_valid_d = 1'b0;
    end else if (step) begin
      pos_d = pos_q + IW'(1);
      if (expire && (cnt_q < CNT_W'(RESULT_CAP))) begin
        push         = pend_valid_q;
        push_status  = ST_EXPIRED;
        push_slot    = pend_slot_q;
        push_last    = 1'b0;
        pend_valid_d = 1'b1;
        pend_slot_d  = idx_slot;
        cnt_d        = cnt_q + CNT_W'(1);
      end
    end else if ((state_q == ST_FINISH) && out_free) begin
      unique case (act_q)
        ACT_ADD: begin
          push        = 1'b1;
          push_status = claim_q ? ST_ADDED : ST_FULL;
          push_slot   = claim_q ? claim_idx_q : '0;
        end
        ACT_DEL: begin
          push        = 1'b1;
          push_status = ST_DELETED;
          push_slot   = id_q;
        end
        ACT_RUN: begin
          push         = 1'b1;
          push_status  = pend_valid_q ? ST_EXPIRED : ST_NONE;
          push_slot    = pend_valid_q ? pend_slot_q : '0;
          pend_valid_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pos_q        <= '0;
      claim_q      <= 1'b0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      claim_q      <= accept ? 1'b0 : claim_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= push || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= action_i;
      now_q  <= now_ms_i;
      ival_q <= period_ms_i;
      id_q   <= slot_id_i;
    end
    claim_idx_q <= claim_idx_d;
    pend_slot_q <= pend_slot_d;
    if (push) begin
      out_status_q <= push_status;
      out_slot_q   <= push_slot;
      out_last_q   <= push_last;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign shift_o     = step;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign slot_o      = out_slot_q;
  assign last_o      = out_last_q;

  `ASSERT_PROP(a_cnt_cap, clk_i, rst_ni, cnt_q <= CNT_W'(RESULT_CAP))
  `ASSERT_PROP(a_pend_run, clk_i, rst_ni, pend_valid_q |-> (act_q == ACT_RUN))
  `ASSERT_NEVER(a_idle_pend, clk_i, rst_ni, (state_q == ST_IDLE) && pend_valid_q)
  `ASSERT_PROP(a_scan_end, clk_i, rst_ni,
               (step && (pos_q == LAST_POS)) |=> (state_q == ST_FINISH))

endmodule

// ----- design/periodic_timer_slot_bank.sv -----
// Periodic timer slot bank: each request passes through an accept step, a ring rotation of
// NUM_SLOTS steps and a finish step before another request is accepted. One slot reaches
// the update logic per cycle while the output is not stalled. An expiry is held until the
// next expiring slot passes or the finish step, so its last flag is known; each step waits
// on a stalled output.
// Asynchronous active-low reset clears all slots to inactive.
`timescale 1ns / 1ps

module periodic_timer_slot_bank
  import ptsb_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // action[1:0], now_ms[33:2], period_ms[65:34], slot_id[69:66], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // status[2:0], slot[6:3], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                  m_axis_tlast_o
);

  // Ring of cells. The last cell is the head: it holds the slot whose index equals the
  // step count. Its updated entry re-enters at cell zero, so a full rotation of
  // NUM_SLOTS steps brings every slot back to its home cell.
  slot_t   ring [NUM_SLOTS];
  slot_t   wr;
  logic    shift;
  status_e status;
  logic [SLOT_W-1:0] slot;

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    if (k == 0) begin : g_first
      ptsb_cell u_cell (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .en_i  (shift),
        .d_i   (wr),
        .q_o   (ring[k])
      );
    end else begin : g_next
      ptsb_cell u_cell (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .en_i  (shift),
        .d_i   (ring[k-1]),
        .q_o   (ring[k])
      );
    end
  end

  // Hold the request, update the head slot, and stage the results.
  ptsb_ctrl #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .action_i     (s_axis_tdata_i[ACT_W-1:0]),
    .now_ms_i     (s_axis_tdata_i[ACT_W +: TIME_W]),
    .period_ms_i  (s_axis_tdata_i[ACT_W+TIME_W +: TIME_W]),
    .slot_id_i    (s_axis_tdata_i[ACT_W+2*TIME_W +: SLOT_W]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .status_o     (status),
    .slot_o       (slot),
    .last_o       (m_axis_tlast_o),
    .shift_o      (shift),
    .head_i       (ring[NUM_SLOTS-1]),
    .wr_o         (wr)
  );

  // Pack the result fields, low field first, and zero the pad bits.
  assign m_axis_tdata_o = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, slot, status};

endmodule

// ----- test/periodic_timer_slot_bank_test.sv -----
// Self-checking testbench for the periodic timer slot bank: add, delete, run and reserved requests
// against a cycle-free timer table predictor. Depends on ptsb_pkg and the RTL top level only.
`timescale 1ns / 1ps

module periodic_timer_slot_bank_test;
  import ptsb_pkg::*;

  localparam int TB_SLOTS       = NUM_SLOTS_DEF;
  localparam int MAX_WAIT       = 6;
  localparam int RANDOM_ITEMS   = 440;
  localparam int WATCHDOG_LIMIT = 4000;
  // Idle stretch held after the last expected result; any extra result in it fails the test.
  localparam int DRAIN_CYCLES   = 4 * (TB_SLOTS + 2);

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] period_ms;
    logic [SLOT_W-1:0] slot_id;
    int unsigned       gap;
  } timer_req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                last;
  } timer_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  // Handshake seen at the last rising edge, read by the falling-edge drivers.
  logic req_fire = 1'b0;
  logic res_fire = 1'b0;

  timer_req_t    pending_requests[$];
  timer_result_t expected_results[$];

  // Predictor copy of the timer table.
  logic              tm_active[TB_SLOTS];
  logic [TIME_W-1:0] tm_period[TB_SLOTS];
  logic [TIME_W-1:0] tm_start[TB_SLOTS];

  timer_req_t    next_req;
  logic          have_next = 1'b0;
  int unsigned   gap_left = 0;
  int unsigned   sink_wait = 0;
  bit            source_calm = 1'b0;
  bit            sink_calm = 1'b0;
  bit            failed = 1'b0;
  int unsigned   stall_cycles = 0;
  timer_result_t got_exp;
  logic [TIME_W-1:0] model_ms;

  periodic_timer_slot_bank #(
    .NUM_SLOTS(TB_SLOTS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tlast_o (m_axis_tlast)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Pack a request: action, now_ms, period_ms, slot_id from the lowest bit up, zero pad.
  function automatic logic [IN_DATA_W-1:0] pack_request(timer_req_t req);
    logic [IN_DATA_W-1:0] data;
    data = '0;
    data[ACT_W-1:0]                                      = req.action;
    data[ACT_W +: TIME_W]                                = req.now_ms;
    data[ACT_W + TIME_W +: TIME_W]                       = req.period_ms;
    data[ACT_W + 2 * TIME_W +: SLOT_W]                   = req.slot_id;
    return data;
  endfunction

  // Work out the results that one accepted request causes and advance the table.
  task automatic predict_timer_results(logic [IN_DATA_W-1:0] data);
    logic [ACT_W-1:0]  action;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] period_ms;
    logic [SLOT_W-1:0] slot_id;
    timer_result_t     res;
    int                n_expired;
    bit                placed;
    action      = data[ACT_W-1:0];
    now_ms      = data[ACT_W +: TIME_W];
    period_ms   = data[ACT_W + TIME_W +: TIME_W];
    slot_id     = data[ACT_W + 2 * TIME_W +: SLOT_W];
    n_expired   = 0;
    placed      = 1'b0;
    res.last    = 1'b1;
    case (action)
      ACT_ADD: begin
        // Claim the lowest free slot, or report a full bank.
        for (int i = 0; i < TB_SLOTS; i++) begin
          if (!placed && !tm_active[i]) begin
            tm_active[i] = 1'b1;
            tm_period[i] = period_ms;
            tm_start[i]  = now_ms;
            res.status   = ST_ADDED;
            res.slot     = SLOT_W'(i);
            placed       = 1'b1;
          end
        end
        if (!placed) begin
          res.status = ST_FULL;
          res.slot   = '0;
        end
        expected_results.push_back(res);
      end
      ACT_DEL: begin
        // Freeing an idle or out-of-range slot still reports the given id.
        if (int'(slot_id) < TB_SLOTS) tm_active[slot_id] = 1'b0;
        res.status = ST_DELETED;
        res.slot   = slot_id;
        expected_results.push_back(res);
      end
      ACT_RUN: begin
        // Elapsed time is the modular difference, so a wrapped clock still works.
        for (int i = 0; i < TB_SLOTS; i++) begin
          if (tm_active[i] && (TIME_W'(now_ms - tm_start[i]) >= tm_period[i])) begin
            tm_start[i] = now_ms;
            if (n_expired < RESULT_CAP) begin
              res.status = ST_EXPIRED;
              res.slot   = SLOT_W'(i);
              res.last   = 1'b0;
              expected_results.push_back(res);
              n_expired++;
            end
          end
        end
        if (n_expired == 0) begin
          res.status = ST_NONE;
          res.slot   = '0;
          res.last   = 1'b1;
          expected_results.push_back(res);
        end else begin
          expected_results[expected_results.size() - 1].last = 1'b1;
        end
      end
      default: ;  // reserved action: no result, no change
    endcase
  endtask

  task automatic push_request(logic [ACT_W-1:0] action, logic [TIME_W-1:0] now_ms,
                              logic [TIME_W-1:0] period_ms, logic [SLOT_W-1:0] slot_id);
    timer_req_t req;
    // Flip between randomly gapped and back-to-back stretches now and then.
    if ($urandom_range(0, 29) == 0) source_calm = ~source_calm;
    req.action      = action;
    req.now_ms      = now_ms;
    req.period_ms   = period_ms;
    req.slot_id     = slot_id;
    req.gap         = source_calm ? 0 : $urandom_range(0, MAX_WAIT);
    pending_requests.push_back(req);
  endtask

  // Request driver: present the next queued request after its gap, hold until accepted.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || req_fire)) begin
      if (!have_next && pending_requests.size() != 0) begin
        next_req  = pending_requests.pop_front();
        gap_left  = next_req.gap;
        have_next = 1'b1;
      end
      if (have_next && gap_left == 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_request(next_req);
        have_next = 1'b0;
      end else begin
        s_axis_tvalid <= 1'b0;
        if (have_next) gap_left--;
      end
    end
  end

  // Result sink: drop ready for a random stretch after each accepted result.
  always @(negedge clk_i) begin
    if (res_fire) begin
      if ($urandom_range(0, 39) == 0) sink_calm = ~sink_calm;
      sink_wait = sink_calm ? 0 : $urandom_range(0, MAX_WAIT);
    end
    if (sink_wait != 0) begin
      m_axis_tready <= 1'b0;
      sink_wait--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: predict on accepted requests, check accepted results, watch for a hang.
  always @(posedge clk_i) begin
    req_fire <= s_axis_tvalid && s_axis_tready;
    res_fire <= m_axis_tvalid && m_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_timer_results(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status %0d slot %0d last %0b", $time,
                   m_axis_tdata[STATUS_W-1:0], m_axis_tdata[STATUS_W +: SLOT_W],
                   m_axis_tlast);
          failed = 1'b1;
        end else begin
          got_exp = expected_results.pop_front();
          if (m_axis_tdata[STATUS_W-1:0] !== got_exp.status ||
              m_axis_tdata[STATUS_W +: SLOT_W] !== got_exp.slot ||
              m_axis_tlast !== got_exp.last) begin
            $display("%0t: status/slot/last expected %0d/%0d/%0b, actual %0d/%0d/%0b",
                     $time, got_exp.status, got_exp.slot, got_exp.last,
                     m_axis_tdata[STATUS_W-1:0], m_axis_tdata[STATUS_W +: SLOT_W],
                     m_axis_tlast);
            failed = 1'b1;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (s_axis_tvalid || expected_results.size() != 0) begin
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
          $display("periodic_timer_slot_bank test failed");
          $finish;
        end else begin
          stall_cycles <= stall_cycles + 1;
        end
      end
    end
  end

  initial begin
    int unsigned n_random;
    int unsigned pick;
    logic [TIME_W-1:0] base_ms;
    for (int i = 0; i < TB_SLOTS; i++) begin
      tm_active[i] = 1'b0;
      tm_period[i] = '0;
      tm_start[i]  = '0;
    end

    // Directed part. Start just below the wrap point of the millisecond clock.
    base_ms = 32'hFFFF_FFF0;
    push_request(ACT_ADD, base_ms, 32'd0, 4'd0);             // zero period: expires every run
    push_request(ACT_ADD, base_ms, 32'hFFFF_FFFF, 4'hF);     // longest period
    push_request(ACT_ADD, base_ms + 1, 32'd20, 4'd0);
    push_request(ACT_RUN, base_ms + 5, 32'hFFFF_FFFF, 4'hF); // only the zero-period slot
    push_request(ACT_RUN, 32'h0000_0010, 32'd0, 4'd0);       // clock wrapped, slot 2 due
    push_request(ACT_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
    for (int i = 3; i < TB_SLOTS; i++) begin
      push_request(ACT_ADD, 32'h0000_0020, $urandom_range(0, 40), 4'd0);
    end
    push_request(ACT_ADD, 32'h0000_0020, 32'd5, 4'd0);       // bank full
    push_request(ACT_DEL, 32'h0000_0021, 32'd0, 4'hF);       // highest slot id
    push_request(ACT_DEL, 32'h0000_0021, 32'd0, 4'hF);       // delete of a free slot
    push_request(ACT_DEL, 32'h0000_0022, 32'd0, 4'd1);
    push_request(ACT_ADD, 32'h0000_0023, 32'd1000, 4'd0);    // reuses slot 1
    push_request(ACT_RUN, 32'h0000_0050, 32'd0, 4'd0);

    // Random part: a slowly advancing clock, mostly short periods, some long jumps.
    model_ms = 32'hFFFF_8000;
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        push_request(ACT_RSVD, $urandom, $urandom, SLOT_W'($urandom_range(0, 15)));
      end else begin
        n_random++;
        if (pick < 34) begin
          model_ms = model_ms + $urandom_range(0, 10);
          pick = $urandom_range(0, 9);
          push_request(ACT_ADD, model_ms,
                       (pick < 7) ? TIME_W'($urandom_range(0, 300)) :
                       (pick < 9) ? TIME_W'($urandom_range(0, 20)) : TIME_W'($urandom),
                       SLOT_W'($urandom_range(0, 15)));
        end else if (pick < 58) begin
          model_ms = model_ms + $urandom_range(0, 10);
          push_request(ACT_DEL, model_ms, $urandom, SLOT_W'($urandom_range(0, 15)));
        end else begin
          // Mostly small steps; now and then jump anywhere, backward jumps included.
          if ($urandom_range(0, 19) == 0) model_ms = $urandom;
          else model_ms = model_ms + $urandom_range(0, 150);
          push_request(ACT_RUN, model_ms, $urandom, SLOT_W'($urandom_range(0, 15)));
        end
      end
    end

    repeat (5) @(posedge clk_i);
    #5 rst_ni = 1'b1;

    // Wait until every request has gone in and every expected result has come out.
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_requests.size() != 0 || have_next || s_axis_tvalid ||
               expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    #1;
    if (!failed && expected_results.size() == 0) begin
      $display("periodic_timer_slot_bank test passed");
    end else begin
      $display("periodic_timer_slot_bank test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/ptsb_pkg.sv
design/ptsb_cell.sv
design/ptsb_ctrl.sv
design/periodic_timer_slot_bank.sv
test/periodic_timer_slot_bank_test.sv
